@@ sv/abld_pkg.sv @@
// ----------------------------------------------------------------------------
// abld_pkg: shared types and constants of the analog button ladder decoder
// Band thresholds, mode codes, register indexes and the item structures.
// ----------------------------------------------------------------------------
package abld_pkg;

  // Machine modes
  localparam logic [2:0] ModeIdle  = 3'd0;
  localparam logic [2:0] ModeJog   = 3'd1;
  localparam logic [2:0] ModeCycle = 3'd2;
  localparam logic [2:0] ModeHold  = 3'd3;
  localparam logic [2:0] ModeAlarm = 3'd4;

  // Jog ladder bands
  localparam logic [7:0] JogLow  = 8'd63;
  localparam logic [7:0] JogHigh = 8'd191;

  // Function ladder bands
  localparam logic [7:0] BandStop    = 8'd21;
  localparam logic [7:0] BandStart   = 8'd58;
  localparam logic [7:0] BandSpindle = 8'd85;
  localparam logic [7:0] BandAux     = 8'd105;
  localparam logic [7:0] BandHome    = 8'd121;

  // Feed override
  localparam logic [7:0] OvrMin   = 8'd50;
  localparam logic [7:0] OvrMax   = 8'd150;
  localparam logic [7:0] OvrStep  = 8'd5;
  localparam logic [7:0] OvrReset = 8'd100;

  localparam logic [7:0] TolReset = 8'd2;

  // Spindle commands
  localparam logic [1:0] SpinNone = 2'd0;
  localparam logic [1:0] SpinMin  = 2'd1;
  localparam logic [1:0] SpinOff  = 2'd2;

  // Configuration register indexes
  localparam logic RegHomingEnabled   = 1'b0;
  localparam logic RegStableTolerance = 1'b1;

  // Button bit positions
  localparam int unsigned BitXPos  = 0;
  localparam int unsigned BitYPos  = 1;
  localparam int unsigned BitXNeg  = 2;
  localparam int unsigned BitYNeg  = 3;
  localparam int unsigned BitOvr   = 4;
  localparam int unsigned BitAux   = 5;
  localparam int unsigned BitStart = 6;
  localparam int unsigned BitHome  = 7;

  typedef struct packed {
    logic [7:0] clear_bits;
    logic       spindle_is_off;
    logic [2:0] machine_mode;
    logic [7:0] other_level_delayed;
    logic [7:0] other_level_second;
    logic [7:0] other_level_first;
    logic [7:0] jog_y_level;
    logic [7:0] jog_x_level;
  } item_t;

  typedef struct packed {
    logic [1:0] spindle_command;
    logic       request_cycle_start;
    logic       request_feed_hold;
    logic       request_reset;
  } req_t;

endpackage

@@ sv/abld_jog.sv @@
// ----------------------------------------------------------------------------
// abld_jog: jog ladder decode and feed override stepping
// Sets the direction bits in idle or jog and steps the override in cycle/hold.
// ----------------------------------------------------------------------------
module abld_jog (
  input  logic [7:0] pressed_i,
  input  logic [7:0] clear_bits_i,
  input  logic [7:0] jog_x_level_i,
  input  logic [7:0] jog_y_level_i,
  input  logic [2:0] machine_mode_i,
  input  logic [7:0] override_i,
  output logic [7:0] pressed_o,
  output logic [7:0] override_o,
  output logic       changed_o
);

  logic jogging;
  logic running;
  logic down;

  assign jogging = (machine_mode_i == abld_pkg::ModeIdle) ||
                   (machine_mode_i == abld_pkg::ModeJog);
  assign running = (machine_mode_i == abld_pkg::ModeCycle) ||
                   (machine_mode_i == abld_pkg::ModeHold);
  assign down    = jog_y_level_i < abld_pkg::JogLow;

  always_comb begin
    pressed_o  = pressed_i & ~clear_bits_i;
    override_o = override_i;
    changed_o  = 1'b0;

    if (jog_x_level_i < abld_pkg::JogLow) begin
      if (jogging) begin
        pressed_o[abld_pkg::BitXNeg] = 1'b0;
        pressed_o[abld_pkg::BitXPos] = 1'b1;
      end
    end else if (jog_x_level_i < abld_pkg::JogHigh) begin
      if (jogging) begin
        pressed_o[abld_pkg::BitXPos] = 1'b0;
        pressed_o[abld_pkg::BitXNeg] = 1'b1;
      end
    end else begin
      pressed_o[abld_pkg::BitXPos] = 1'b0;
      pressed_o[abld_pkg::BitXNeg] = 1'b0;
    end

    if (jog_y_level_i < abld_pkg::JogHigh) begin
      if (jogging) begin
        pressed_o[abld_pkg::BitYPos] = down;
        pressed_o[abld_pkg::BitYNeg] = !down;
      end else if (running && !pressed_o[abld_pkg::BitOvr]) begin
        // One override step per press; the latch holds until release
        pressed_o[abld_pkg::BitOvr] = 1'b1;
        if (down && override_i > abld_pkg::OvrMin) begin
          override_o = (override_i >= abld_pkg::OvrMin + abld_pkg::OvrStep) ?
                       override_i - abld_pkg::OvrStep : abld_pkg::OvrMin;
          changed_o  = 1'b1;
        end else if (!down && override_i < abld_pkg::OvrMax) begin
          override_o = (override_i <= abld_pkg::OvrMax - abld_pkg::OvrStep) ?
                       override_i + abld_pkg::OvrStep : abld_pkg::OvrMax;
          changed_o  = 1'b1;
        end
      end
    end else begin
      pressed_o[abld_pkg::BitYPos] = 1'b0;
      pressed_o[abld_pkg::BitYNeg] = 1'b0;
      pressed_o[abld_pkg::BitOvr]  = 1'b0;
    end
  end

endmodule

@@ sv/abld_func.sv @@
// ----------------------------------------------------------------------------
// abld_func: function ladder decode
// Checks stability, tracks release and turns a band into a request or bit.
// ----------------------------------------------------------------------------
module abld_func (
  input  logic [7:0]    pressed_i,
  input  logic [7:0]    other_level_first_i,
  input  logic [7:0]    other_level_second_i,
  input  logic [7:0]    other_level_delayed_i,
  input  logic [2:0]    machine_mode_i,
  input  logic          spindle_is_off_i,
  input  logic          latch_i,
  input  logic          homing_enabled_i,
  input  logic [7:0]    stable_tolerance_i,
  output logic [7:0]    pressed_o,
  output logic          latch_o,
  output abld_pkg::req_t req_o
);

  logic [7:0] diff_first;
  logic [7:0] diff_delayed;
  logic       stable;
  logic       confirmed;
  logic       is_idle;
  logic       consume;

  assign diff_first   = (other_level_first_i > other_level_second_i) ?
                        other_level_first_i - other_level_second_i :
                        other_level_second_i - other_level_first_i;
  assign diff_delayed = (other_level_delayed_i > other_level_second_i) ?
                        other_level_delayed_i - other_level_second_i :
                        other_level_second_i - other_level_delayed_i;
  assign stable    = (pressed_i == 8'd0) && (diff_first <= stable_tolerance_i);
  assign confirmed = diff_delayed <= stable_tolerance_i;
  assign is_idle   = machine_mode_i == abld_pkg::ModeIdle;

  always_comb begin
    pressed_o = pressed_i;
    latch_o   = latch_i;
    req_o     = '0;
    consume   = 1'b1;

    if (stable) begin
      if (other_level_second_i >= abld_pkg::BandHome) begin
        latch_o = 1'b1;
      end else if (latch_i) begin
        if (other_level_second_i < abld_pkg::BandStop) begin
          req_o.request_reset = 1'b1;
        end else if (other_level_second_i < abld_pkg::BandStart) begin
          if (is_idle) begin
            if (confirmed) pressed_o[abld_pkg::BitStart] = 1'b1;
            else consume = 1'b0;
          end else if (machine_mode_i == abld_pkg::ModeCycle) begin
            req_o.request_feed_hold = 1'b1;
          end else if (machine_mode_i == abld_pkg::ModeHold) begin
            req_o.request_cycle_start = 1'b1;
          end
        end else if (other_level_second_i < abld_pkg::BandSpindle) begin
          if (is_idle) begin
            if (confirmed) begin
              req_o.spindle_command = spindle_is_off_i ? abld_pkg::SpinMin :
                                                         abld_pkg::SpinOff;
            end else begin
              consume = 1'b0;
            end
          end
        end else if (other_level_second_i < abld_pkg::BandAux) begin
          if (is_idle) begin
            if (confirmed) pressed_o[abld_pkg::BitAux] = 1'b1;
            else consume = 1'b0;
          end
        end else begin
          if (homing_enabled_i &&
              (is_idle || machine_mode_i == abld_pkg::ModeAlarm)) begin
            if (confirmed) pressed_o[abld_pkg::BitHome] = 1'b1;
            else consume = 1'b0;
          end
        end
        // Drop the latch once the press is used
        if (consume) latch_o = 1'b0;
      end
    end
  end

endmodule

@@ sv/analog_button_ladder_decoder_core.sv @@
// ----------------------------------------------------------------------------
// analog_button_ladder_decoder_core: button ladder poll decoder
// Decodes jog, override and function button ladders from one ADC poll.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid_i/tready_o       tdata, 56 bits, one poll
// m_axis    out        m_axis_tvalid_o/tready_i       tdata, 24 bits, one result
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One poll per cycle sustained while m_axis is not stalled; a poll waits in the input
// register and its result loads into the output register when that register is free
// or its result is being taken.
// The decode state updates as the result register loads.
// A stalled m_axis holds the result; the input register still takes one more
// poll. Reset clears valids and returns override to 100 and the button bits to zero.
// ----------------------------------------------------------------------------
module analog_button_ladder_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] jog_x_level, [15:8] jog_y_level, [23:16] other_level_first,
  // [31:24] other_level_second, [39:32] other_level_delayed,
  // [42:40] machine_mode, [43] spindle_is_off, [51:44] clear_bits, rest zero
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] button_bits, [15:8] feed_override, [16] override_changed,
  // [17] request_reset, [18] request_feed_hold, [19] request_cycle_start,
  // [21:20] spindle_command, rest zero
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic            in_valid_q, in_valid_d;
  abld_pkg::item_t item_q;
  logic            out_valid_q, out_valid_d;
  logic [21:0]     out_q;
  logic [7:0]      pressed_q, pressed_d;
  logic [7:0]      override_q, override_d;
  logic            latch_q, latch_d;
  logic            homing_q;
  logic [7:0]      tol_q;

  logic            advance;
  logic            s_accept;
  logic [7:0]      jog_pressed;
  logic            changed;
  abld_pkg::req_t  req;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

  abld_jog u_jog (
    .pressed_i      (pressed_q),
    .clear_bits_i   (item_q.clear_bits),
    .jog_x_level_i  (item_q.jog_x_level),
    .jog_y_level_i  (item_q.jog_y_level),
    .machine_mode_i (item_q.machine_mode),
    .override_i     (override_q),
    .pressed_o      (jog_pressed),
    .override_o     (override_d),
    .changed_o      (changed)
  );

  abld_func u_func (
    .pressed_i             (jog_pressed),
    .other_level_first_i   (item_q.other_level_first),
    .other_level_second_i  (item_q.other_level_second),
    .other_level_delayed_i (item_q.other_level_delayed),
    .machine_mode_i        (item_q.machine_mode),
    .spindle_is_off_i      (item_q.spindle_is_off),
    .latch_i               (latch_q),
    .homing_enabled_i      (homing_q),
    .stable_tolerance_i    (tol_q),
    .pressed_o             (pressed_d),
    .latch_o               (latch_d),
    .req_o                 (req)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pressed_q   <= '0;
      override_q  <= abld_pkg::OvrReset;
      latch_q     <= 1'b0;
      homing_q    <= 1'b0;
      tol_q       <= abld_pkg::TolReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && in_valid_q) begin
        pressed_q  <= pressed_d;
        override_q <= override_d;
        latch_q    <= latch_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          abld_pkg::RegHomingEnabled:   homing_q <= cfg_data_i[0];
          abld_pkg::RegStableTolerance: tol_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) item_q <= abld_pkg::item_t'(s_axis_tdata_i[51:0]);
    if (advance && in_valid_q) begin
      out_q <= {req.spindle_command, req.request_cycle_start, req.request_feed_hold,
                req.request_reset, changed, override_d, pressed_d};
    end
  end

endmodule

@@ sv/abld_checker.sv @@
// ----------------------------------------------------------------------------
// abld_checker: port-level checks of the button ladder decoder
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module abld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
    $stable(m_axis_tdata_o))
    else $error("stalled result transaction changed");

  // Input side blocks only when a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:8] >= abld_pkg::OvrMin &&
    m_axis_tdata_o[15:8] <= abld_pkg::OvrMax)
    else $error("feed override out of range");

  // At most one request or spindle command per result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0({m_axis_tdata_o[19:17], |m_axis_tdata_o[21:20]}) &&
    m_axis_tdata_o[21:20] != 2'd3)
    else $error("conflicting requests in one result");

endmodule

bind analog_button_ladder_decoder_core abld_checker u_abld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ tb/ladder_decode_checker.sv @@
// ----------------------------------------------------------------------------
// ladder_decode_checker: result checker for the button ladder poll decoder
// Watches the poll, result and register channels, decodes every accepted
// poll with its own copy of the decoder state and compares each result with
// the oldest decoded one, field by field.
// ----------------------------------------------------------------------------
module ladder_decode_checker
  import abld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [55:0]        s_data_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [23:0]        m_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        outstanding_o
);

  typedef struct packed {
    logic [1:0] pad;
    req_t       req;
    logic       changed;
    logic [7:0] ovr;
    logic [7:0] bits;
  } poll_result_t;

  logic         homing_on    = 1'b0;
  logic [7:0]   tolerance    = TolReset;
  logic [7:0]   held_bits    = '0;
  logic [7:0]   override_pct = OvrReset;
  logic         armed        = 1'b0;
  int unsigned  fail_total   = 0;
  poll_result_t pending_decodes[$];

  assign fail_count_o = fail_total;

  function automatic logic [7:0] level_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic poll_result_t decode_poll(input item_t p);
    poll_result_t r;
    logic         jogging;
    logic         running;
    logic         down;
    logic         confirmed;
    logic         consume;
    r = '0;
    jogging = (p.machine_mode == ModeIdle) || (p.machine_mode == ModeJog);
    running = (p.machine_mode == ModeCycle) || (p.machine_mode == ModeHold);
    held_bits = held_bits & ~p.clear_bits;

    if (p.jog_x_level < JogLow) begin
      if (jogging) begin
        held_bits[BitXPos] = 1'b1;
        held_bits[BitXNeg] = 1'b0;
      end
    end else if (p.jog_x_level < JogHigh) begin
      if (jogging) begin
        held_bits[BitXNeg] = 1'b1;
        held_bits[BitXPos] = 1'b0;
      end
    end else begin
      held_bits[BitXPos] = 1'b0;
      held_bits[BitXNeg] = 1'b0;
    end

    if (p.jog_y_level < JogHigh) begin
      down = p.jog_y_level < JogLow;
      if (jogging) begin
        held_bits[BitYPos] = down;
        held_bits[BitYNeg] = !down;
      end else if (running && !held_bits[BitOvr]) begin
        // one override step per press, the latch holds until release
        held_bits[BitOvr] = 1'b1;
        if (down && override_pct > OvrMin) begin
          override_pct = (override_pct >= OvrMin + OvrStep) ? override_pct - OvrStep : OvrMin;
          r.changed = 1'b1;
        end else if (!down && override_pct < OvrMax) begin
          override_pct = (override_pct <= OvrMax - OvrStep) ? override_pct + OvrStep : OvrMax;
          r.changed = 1'b1;
        end
      end
    end else begin
      held_bits[BitYPos] = 1'b0;
      held_bits[BitYNeg] = 1'b0;
      held_bits[BitOvr]  = 1'b0;
    end

    if (held_bits == '0 &&
        level_gap(p.other_level_first, p.other_level_second) <= tolerance) begin
      confirmed = level_gap(p.other_level_delayed, p.other_level_second) <= tolerance;
      if (p.other_level_second >= BandHome) begin
        armed = 1'b1;
      end else if (armed) begin
        consume = 1'b1;
        if (p.other_level_second < BandStop) begin
          r.req.request_reset = 1'b1;
        end else if (p.other_level_second < BandStart) begin
          if (p.machine_mode == ModeIdle) begin
            if (confirmed) held_bits[BitStart] = 1'b1;
            else consume = 1'b0;
          end else if (p.machine_mode == ModeCycle) begin
            r.req.request_feed_hold = 1'b1;
          end else if (p.machine_mode == ModeHold) begin
            r.req.request_cycle_start = 1'b1;
          end
        end else if (p.other_level_second < BandSpindle) begin
          if (p.machine_mode == ModeIdle) begin
            if (confirmed) r.req.spindle_command = p.spindle_is_off ? SpinMin : SpinOff;
            else consume = 1'b0;
          end
        end else if (p.other_level_second < BandAux) begin
          if (p.machine_mode == ModeIdle) begin
            if (confirmed) held_bits[BitAux] = 1'b1;
            else consume = 1'b0;
          end
        end else if (homing_on &&
                     (p.machine_mode == ModeIdle || p.machine_mode == ModeAlarm)) begin
          if (confirmed) held_bits[BitHome] = 1'b1;
          else consume = 1'b0;
        end
        // a press that did its job, or was invalid in this mode, disarms
        if (consume) armed = 1'b0;
      end
    end

    r.bits = held_bits;
    r.ovr  = override_pct;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    poll_result_t want;
    poll_result_t got;
    if (!rst_ni) begin
      pending_decodes.delete();
      homing_on     = 1'b0;
      tolerance     = TolReset;
      held_bits     = '0;
      override_pct  = OvrReset;
      armed         = 1'b0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegHomingEnabled) homing_on = cfg_data_i[0];
        else tolerance = cfg_data_i;
      end
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (pending_decodes.size() == 0) begin
          $display("%0t: expected no result, got %h", $time, m_data_i);
          fail_total++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("button_bits", want.bits, got.bits);
          check_field("feed_override", want.ovr, got.ovr);
          check_field("override_changed", want.changed, got.changed);
          check_field("request_reset", want.req.request_reset, got.req.request_reset);
          check_field("request_feed_hold", want.req.request_feed_hold,
                      got.req.request_feed_hold);
          check_field("request_cycle_start", want.req.request_cycle_start,
                      got.req.request_cycle_start);
          check_field("spindle_command", want.req.spindle_command,
                      got.req.spindle_command);
        end
      end
      if (s_valid_i && s_ready_i) begin
        pending_decodes.push_back(decode_poll(item_t'(s_data_i[51:0])));
      end
      outstanding_o <= pending_decodes.size();
    end
  end

endmodule

@@ tb/tb_analog_button_ladder_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_analog_button_ladder_decoder_core: poll decoder testbench
// Drives directed polls for every button band and special case, then random
// press and release sequences under several register settings, with random
// gaps and result stalls. A checker beside the decoder predicts and compares.
// ----------------------------------------------------------------------------
module tb_analog_button_ladder_decoder_core;
  import abld_pkg::*;

  localparam logic [2:0]  ModeOther  = 3'd5;
  localparam logic [2:0]  ModeUnused = 3'd7;
  localparam int unsigned QuietLimit = 1000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = RegHomingEnabled;
  logic [7:0]  cfg_data  = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned polls_sent   = 0;
  int unsigned quiet_cycles = 0;
  bit          idling       = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  analog_button_ladder_decoder_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  ladder_decode_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_valid_i     (s_tvalid),
    .s_ready_i     (s_tready),
    .s_data_i      (s_tdata),
    .m_valid_i     (m_tvalid),
    .m_ready_i     (m_tready),
    .m_data_i      (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts while idling is enabled
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  function automatic item_t poll(input logic [7:0] jx, input logic [7:0] jy,
                                 input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] delayed, input logic [2:0] mode,
                                 input logic spin_off, input logic [7:0] clear);
    item_t p;
    p.jog_x_level         = jx;
    p.jog_y_level         = jy;
    p.other_level_first   = first;
    p.other_level_second  = second;
    p.other_level_delayed = delayed;
    p.machine_mode        = mode;
    p.spindle_is_off      = spin_off;
    p.clear_bits          = clear;
    return p;
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] level, input int spread);
    int v;
    v = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // mostly released jogs so the function ladder gets read; readings near agree
  function automatic item_t ladder_poll(input logic pressing);
    item_t      p;
    logic [7:0] second;
    p.machine_mode = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(ModeIdle, ModeAlarm))
                                                : 3'($urandom_range(ModeOther, ModeUnused));
    p.spindle_is_off = 1'($urandom);
    p.jog_x_level = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(JogHigh, 255));
    p.jog_y_level = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(JogHigh, 255));
    p.clear_bits  = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
    second = pressing ? 8'($urandom_range(0, BandHome - 1)) : 8'($urandom_range(BandHome, 255));
    p.other_level_second  = second;
    p.other_level_first   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : jitter(second, 2);
    p.other_level_delayed = ($urandom_range(0, 5) == 0) ? 8'($urandom) : jitter(second, 2);
    return p;
  endfunction

  task automatic send_poll(input item_t p);
    if (idling && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, p};
    do @(posedge clk); while (!s_tready);
    polls_sent++;
  endtask

  // hold polls back until every result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic configure(input logic homing, input logic [7:0] tol);
    cfg_valid <= 1'b1;
    cfg_index <= RegHomingEnabled;
    cfg_data  <= {7'b0, homing};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= RegStableTolerance;
    cfg_data  <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    item_t       p;
    logic        up;
    goal = polls_sent + count;
    while (polls_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1: send_poll(item_t'(52'({$urandom, $urandom})));
        2: begin
          // run the override into its clamp with press/release pairs
          up = 1'($urandom);
          repeat (12) begin
            p = ladder_poll(1'b0);
            p.machine_mode = $urandom_range(0, 1) ? ModeCycle : ModeHold;
            p.jog_y_level = up ? 8'($urandom_range(JogLow, JogHigh - 1))
                               : 8'($urandom_range(0, JogLow - 1));
            send_poll(p);
            p.jog_y_level = 8'($urandom_range(JogHigh, 255));
            send_poll(p);
          end
        end
        default: begin
          send_poll(ladder_poll(1'b0));
          send_poll(ladder_poll(1'b1));
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    configure(1'b1, TolReset);
    send_poll(poll(8'd255, 8'd255, 8'd200, 8'd200, 8'd200, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd0, 8'd62, 8'd200, 8'd200, 8'd200, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd63, 8'd190, 8'd200, 8'd200, 8'd200, ModeJog, 1'b0, 8'h00));
    send_poll(poll(8'd62, 8'd63, 8'd200, 8'd200, 8'd200, ModeJog, 1'b0, 8'h00));
    send_poll(poll(8'd191, 8'd191, 8'd121, 8'd121, 8'd121, ModeJog, 1'b1, 8'hFF));
    // stop band acts without confirmation
    send_poll(poll(8'd255, 8'd255, 8'd20, 8'd20, 8'd0, ModeCycle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd21, 8'd21, 8'd23, ModeIdle, 1'b0, 8'h00));
    // the ladder is disarmed here, so these start band presses are ignored
    send_poll(poll(8'd255, 8'd255, 8'd57, 8'd57, 8'd60, ModeIdle, 1'b0, 8'h40));
    send_poll(poll(8'd255, 8'd255, 8'd55, 8'd57, 8'd57, ModeCycle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd200, 8'd200, 8'd200, ModeHold, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd40, 8'd40, 8'd40, ModeHold, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd200, 8'd200, 8'd200, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd58, 8'd58, 8'd58, ModeIdle, 1'b1, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd200, 8'd200, 8'd200, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd84, 8'd84, 8'd84, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd200, 8'd200, 8'd200, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd85, 8'd85, 8'd85, ModeIdle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd130, 8'd130, 8'd130, ModeIdle, 1'b0, 8'hFF));
    // unstable readings are ignored, so the homing press still finds it armed
    send_poll(poll(8'd255, 8'd255, 8'd0, 8'd120, 8'd120, ModeAlarm, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd120, 8'd120, 8'd120, ModeAlarm, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd130, 8'd130, 8'd130, ModeIdle, 1'b0, 8'hFF));
    // aux band is not valid while jogging: press is used up
    send_poll(poll(8'd255, 8'd255, 8'd104, 8'd104, 8'd104, ModeJog, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd0, 8'd200, 8'd200, 8'd200, ModeCycle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd62, 8'd200, 8'd200, 8'd200, ModeCycle, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd255, 8'd200, 8'd200, 8'd200, ModeHold, 1'b0, 8'h00));
    send_poll(poll(8'd255, 8'd190, 8'd200, 8'd200, 8'd200, ModeHold, 1'b0, 8'h00));
    send_poll(poll(8'd0, 8'd0, 8'd10, 8'd10, 8'd10, ModeUnused, 1'b1, 8'h00));
    drain();

    configure(1'b0, 8'd0);
    run_random(300);
    drain();

    configure(1'b1, 8'd255);
    run_random(150);
    drain();
    run_random(150);
    drain();

    configure(1'b1, 8'd5);
    run_random(300);
    drain();

    configure(1'b0, 8'($urandom));
    run_random(250);
    drain();

    idling = 1'b0;
    configure(1'b1, TolReset);
    run_random(450);
    drain();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
